// File: hdl/assert_macros.svh
// Assertion macros for the checker file of the frame decoder.
// No dependencies; the checker takes this header by include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is ignored while reset is high.
`define THFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that is also evaluated during reset.
`define THFD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/thfd_pkg.sv
// Shared types, constants and functions of the temperature/humidity frame decoder.
// No dependencies; every design module of the block imports this package.
package thfd_pkg;

  localparam logic [7:0] CrcInit = 8'hFF;
  localparam logic [7:0] CrcPoly = 8'h31;

  localparam logic [2:0] POS_TEMP_HI  = 3'd0;
  localparam logic [2:0] POS_TEMP_LO  = 3'd1;
  localparam logic [2:0] POS_TEMP_CRC = 3'd2;
  localparam logic [2:0] POS_HUM_HI   = 3'd3;
  localparam logic [2:0] POS_HUM_LO   = 3'd4;
  localparam logic [2:0] POS_HUM_CRC  = 3'd5;

  localparam logic [14:0] TempScale  = 15'd17500;
  localparam logic [14:0] TempOffset = 15'd4500;
  localparam logic [13:0] HumScale   = 14'd10000;
  localparam logic [16:0] FullScale  = 17'd65535;

  typedef struct packed {
    logic signed [14:0] temp_centi;
    logic               temp_valid;
    logic [13:0]        humidity_centi;
    logic               humidity_valid;
  } thfd_result_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

  // Floor division by 65535 of a value below 2^31. The quotient estimate x >> 16
  // leaves a remainder below twice the divisor, so one correction step suffices.
  function automatic logic [14:0] div_full_scale(input logic [30:0] x);
    logic [14:0] q0;
    logic [16:0] r0;
    q0 = x[30:16];
    r0 = {1'b0, x[15:0]} + {2'b00, q0};
    return (r0 >= FullScale) ? q0 + 15'd1 : q0;
  endfunction

endpackage

// File: hdl/thfd_conv.sv
// Converts an assembled 16-bit sensor word to temperature and humidity in hundredths.
// Depends on thfd_pkg for the scale constants and the division by full scale.
module thfd_conv import thfd_pkg::*; (
  input  logic [15:0]        word,
  output logic signed [14:0] temp_centi,
  output logic [13:0]        humidity_centi
);

  logic [30:0] temp_prod;
  logic [30:0] hum_prod;
  logic [14:0] temp_q;
  logic [14:0] hum_q;

  assign temp_prod = {15'd0, word} * {16'd0, TempScale};
  assign hum_prod  = {15'd0, word} * {17'd0, HumScale};

  assign temp_q = div_full_scale(temp_prod);
  assign hum_q  = div_full_scale(hum_prod);

  // The difference always fits 15-bit two's complement, so wrapping arithmetic is exact.
  assign temp_centi     = $signed(temp_q - TempOffset);
  assign humidity_centi = hum_q[13:0];

endmodule

// File: hdl/thfd_frame.sv
// Frame tracking, CRC-8 checking and word assembly for the six-byte response.
// Depends on thfd_pkg and instantiates thfd_conv.
module thfd_frame import thfd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         accept,
  input  logic [7:0]   rx_byte,
  input  logic         frame_start,
  output logic         done,
  output thfd_result_t result
);

  logic [2:0]        position;
  logic [2:0]        position_next;
  logic [7:0]        running_crc;
  logic [7:0]        running_crc_next;
  logic [15:0]       word_value;
  logic [15:0]       word_value_next;
  logic [14:0]       held_temperature;
  logic [14:0]       held_temperature_next;
  logic              held_temp_valid;
  logic              held_temp_valid_next;
  logic [2:0]        pos;
  logic              crc_match;
  logic signed [14:0] conv_temp;
  logic [13:0]       conv_hum;

  thfd_conv u_conv (
    .word           (word_value),
    .temp_centi     (conv_temp),
    .humidity_centi (conv_hum)
  );

  assign pos       = (frame_start || position > POS_HUM_CRC) ? POS_TEMP_HI : position;
  assign crc_match = (running_crc == rx_byte);

  always_comb begin
    running_crc_next      = running_crc;
    word_value_next       = word_value;
    held_temperature_next = held_temperature;
    held_temp_valid_next  = held_temp_valid;
    done                  = 1'b0;
    result.temp_centi     = $signed(held_temperature);
    result.temp_valid     = held_temp_valid;
    result.humidity_centi = crc_match ? conv_hum : 14'd0;
    result.humidity_valid = crc_match;
    unique case (pos)
      POS_TEMP_HI, POS_HUM_HI: begin
        running_crc_next = crc8_byte(CrcInit, rx_byte);
        word_value_next  = {rx_byte, 8'h00};
      end
      POS_TEMP_LO, POS_HUM_LO: begin
        running_crc_next = crc8_byte(running_crc, rx_byte);
        word_value_next  = {word_value[15:8], rx_byte};
      end
      POS_TEMP_CRC: begin
        held_temp_valid_next  = crc_match;
        held_temperature_next = crc_match ? conv_temp : 15'd0;
      end
      default: begin
        done = 1'b1;
      end
    endcase
    position_next = (pos >= POS_HUM_CRC) ? POS_TEMP_HI : pos + 3'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position         <= POS_TEMP_HI;
      running_crc      <= CrcInit;
      word_value       <= 16'd0;
      held_temperature <= 15'd0;
      held_temp_valid  <= 1'b0;
    end else if (accept) begin
      position         <= position_next;
      running_crc      <= running_crc_next;
      word_value       <= word_value_next;
      held_temperature <= held_temperature_next;
      held_temp_valid  <= held_temp_valid_next;
    end
  end

endmodule

// File: hdl/thfd_out_reg.sv
// Output register that holds one decoded result until the receiver takes it.
// Depends on thfd_pkg for the result type.
module thfd_out_reg import thfd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         load,
  input  thfd_result_t load_data,
  output logic         load_ready,
  output logic         valid,
  input  logic         ready,
  output thfd_result_t data
);

  assign load_ready = !valid || ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end
  end

endmodule

// File: hdl/temp_humidity_frame_decoder.sv
// Top level of the temperature/humidity frame decoder.
// Depends on thfd_pkg; instantiates thfd_frame and thfd_out_reg.
//
// Usage: response bytes enter on the rx channel (rx_byte, frame_start, rx_valid,
// rx_ready), one byte per transfer, in frame order: temperature high, low, CRC,
// then humidity high, low, CRC. A byte with frame_start set always begins a new
// frame and drops any partial one. After the sixth byte the next byte starts a
// new frame on its own.
// Results leave on the res channel (temp_centi, temp_valid, humidity_centi,
// humidity_valid, res_valid, res_ready), one transfer per complete frame. A value
// whose CRC failed reads as zero with its valid flag low.
// Throughput is one byte per cycle while the output register can take a result.
// The result of a frame is shown in the cycle after its sixth byte is taken, from a
// single output register. CRC update, word assembly and scaling are combinational.
// While a result is held and the receiver stalls, rx_ready stays low, so no byte
// is taken until the held result leaves.
// Reset (synchronous, active high) clears the frame position, the CRC and the
// held temperature, and empties the output register.
module temp_humidity_frame_decoder import thfd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         rx_byte,
  input  logic               frame_start,
  input  logic               rx_valid,
  output logic               rx_ready,
  output logic signed [14:0] temp_centi,
  output logic               temp_valid,
  output logic [13:0]        humidity_centi,
  output logic               humidity_valid,
  output logic               res_valid,
  input  logic               res_ready
);

  logic         accept;
  logic         done;
  thfd_result_t frame_result;
  thfd_result_t held_result;

  assign accept = rx_valid && rx_ready;

  thfd_frame u_frame (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .rx_byte     (rx_byte),
    .frame_start (frame_start),
    .done        (done),
    .result      (frame_result)
  );

  thfd_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load       (accept && done),
    .load_data  (frame_result),
    .load_ready (rx_ready),
    .valid      (res_valid),
    .ready      (res_ready),
    .data       (held_result)
  );

  assign temp_centi     = held_result.temp_centi;
  assign temp_valid     = held_result.temp_valid;
  assign humidity_centi = held_result.humidity_centi;
  assign humidity_valid = held_result.humidity_valid;

endmodule

// File: hdl/thfd_checker.sv
// Port-level checks of the frame decoder, bound to the top level.
// Depends on assert_macros.svh for the assertion macros.
`include "assert_macros.svh"

module thfd_checker (
  input logic               clk,
  input logic               rst,
  input logic [7:0]         rx_byte,
  input logic               frame_start,
  input logic               rx_valid,
  input logic               rx_ready,
  input logic signed [14:0] temp_centi,
  input logic               temp_valid,
  input logic [13:0]        humidity_centi,
  input logic               humidity_valid,
  input logic               res_valid,
  input logic               res_ready
);

  `THFD_ASSERT(a_temp_zero, (res_valid && !temp_valid) |-> (temp_centi == 15'sd0), "temp not zero")
  `THFD_ASSERT(a_hum_zero, (res_valid && !humidity_valid) |-> (humidity_centi == 14'd0), "humidity not zero")
  `THFD_ASSERT(a_range, res_valid |-> (humidity_centi <= 14'd10000 && temp_centi >= -15'sd4500 && temp_centi <= 15'sd13000), "result out of range")
  `THFD_ASSERT(a_ready_empty, !res_valid |-> rx_ready, "input stalled with empty output")
  `THFD_ASSERT_ALWAYS(a_reset_empty, rst |=> !res_valid, "result after reset")

endmodule

bind temp_humidity_frame_decoder thfd_checker u_checker (.*);
